/* rtl/core/rc4_stream_cipher_defines.svh */
// ----------------------------------------------------------------------------
// RC4 stream cipher assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define RC4_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rc4 assertion failed");
// Condition that must never be seen on a rising clk edge outside reset.
`define RC4_NEVER(lbl, cond) \
  `RC4_ASSERT(lbl, !(cond))
`else
`define RC4_ASSERT(lbl, prop)
`define RC4_NEVER(lbl, cond)
`endif

`endif

/* rtl/core/rc4_pkg.sv */
// ----------------------------------------------------------------------------
// RC4 package
// Shared widths, codes, types and helper functions of the RC4 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int BYTE_W        = 8;
  localparam int PERM_DEPTH    = 1 << BYTE_W;
  localparam int KEY_WORD_W    = 64;
  localparam int LEN_W         = 5;
  localparam int MAX_KEY_BYTES = 16;
  localparam int KPOS_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int CFG_IDX_W     = 2;

  localparam logic [BYTE_W-1:0] BYTE_MAX       = '1;
  localparam logic [LEN_W-1:0]  KEY_LEN_RESET  = LEN_W'(8);

  // Input command codes.
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_CRYPT    = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = CFG_IDX_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_KS_RD_I,
    ST_KS_RD_J,
    ST_KS_SWAP_A,
    ST_KS_SWAP_B,
    ST_CR_RD_J,
    ST_CR_SWAP_A,
    ST_CR_SWAP_B,
    ST_PUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SCHED_INIT,
    OP_KS_RD_I,
    OP_KS_RD_J,
    OP_KS_SWAP_A,
    OP_KS_SWAP_B,
    OP_CR_START,
    OP_CR_RD_J,
    OP_CR_SWAP_A,
    OP_CR_SWAP_B
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last_step;
  } dp_status_t;

  typedef struct packed {
    logic [KEY_WORD_W-1:0] key_low;
    logic [KEY_WORD_W-1:0] key_high;
    logic [LEN_W-1:0]      key_length;
  } key_cfg_t;

  // Key length as used by the schedule: zero counts as one, large values saturate.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(MAX_KEY_BYTES)) begin
      res = LEN_W'(MAX_KEY_BYTES);
    end
    return res;
  endfunction

endpackage

/* rtl/core/rc4_dp.sv */
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation store, indices, key byte selection and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rc4_pkg::dp_cmd_t           cmd,
  output rc4_pkg::dp_status_t        status,
  input  rc4_pkg::key_cfg_t          key_cfg,
  input  logic [rc4_pkg::BYTE_W-1:0] in_data_byte,
  input  logic [rc4_pkg::BYTE_W-1:0] in_expected_byte,
  output logic [rc4_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_match
);

  localparam int BW = rc4_pkg::BYTE_W;

  // Permutation store with registered read; valid bits give identity for unwritten entries.
  logic [BW-1:0]                   mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0]  vld_r, vld_nxt;
  logic [BW-1:0]                   rdata_r;
  logic                            rvld_r;
  logic [BW-1:0]                   raddr_r;

  logic [BW-1:0] raddr, waddr, wdata;
  logic          we;
  logic [BW-1:0] rval;

  logic [BW-1:0]                 i_r, i_nxt;
  logic [BW-1:0]                 j_r, j_nxt;
  logic [BW-1:0]                 t_r, t_nxt;
  logic [BW-1:0]                 sj_r, sj_nxt;
  logic [rc4_pkg::KPOS_W-1:0]    kpos_r, kpos_nxt;
  logic                          hit_i_r, hit_i_nxt;
  logic                          hit_j_r, hit_j_nxt;
  logic [BW-1:0]                 data_r, data_nxt;
  logic [BW-1:0]                 exp_r, exp_nxt;
  logic [BW-1:0]                 res_r, res_nxt;
  logic                          match_r, match_nxt;
  logic [BW-1:0]                 out_byte_r, out_byte_nxt;
  logic                          out_match_r, out_match_nxt;

  logic [2*rc4_pkg::KEY_WORD_W-1:0] key_all;
  logic [BW-1:0]                    key_byte;
  logic [rc4_pkg::LEN_W-1:0]        len_eff;
  logic [rc4_pkg::LEN_W-1:0]        kpos_inc;
  logic [BW-1:0]                    jn_ks;
  logic [BW-1:0]                    j_cr;
  logic [BW-1:0]                    k_addr;
  logic [BW-1:0]                    ks;
  logic [BW-1:0]                    res_cr;

  assign rval     = rvld_r ? rdata_r : raddr_r;
  assign key_all  = {key_cfg.key_high, key_cfg.key_low};
  assign key_byte = key_all[BW*int'(kpos_r) +: BW];
  assign len_eff  = rc4_pkg::eff_len(key_cfg.key_length);
  assign kpos_inc = rc4_pkg::LEN_W'(kpos_r) + rc4_pkg::LEN_W'(1);
  assign jn_ks    = BW'(j_r + rval + key_byte);
  assign j_cr     = BW'(j_r + rval);
  assign k_addr   = BW'(rval + t_r);
  // The keystream read raced the two swap writes, so hits on i or j take the new values.
  assign ks       = hit_j_r ? t_r : (hit_i_r ? sj_r : rval);
  assign res_cr   = data_r ^ ks;

  assign status.last_step = (i_r == rc4_pkg::BYTE_MAX);
  assign out_byte         = out_byte_r;
  assign out_match        = out_match_r;

  always_comb begin
    i_nxt         = i_r;
    j_nxt         = j_r;
    t_nxt         = t_r;
    sj_nxt        = sj_r;
    kpos_nxt      = kpos_r;
    hit_i_nxt     = hit_i_r;
    hit_j_nxt     = hit_j_r;
    data_nxt      = data_r;
    exp_nxt       = exp_r;
    res_nxt       = res_r;
    match_nxt     = match_r;
    raddr         = i_r;
    we            = 1'b0;
    waddr         = i_r;
    wdata         = t_r;
    vld_nxt       = vld_r;
    case (cmd.op)
      rc4_pkg::OP_SCHED_INIT: begin
        i_nxt     = '0;
        j_nxt     = '0;
        kpos_nxt  = '0;
        vld_nxt   = '0;
        res_nxt   = '0;
        match_nxt = 1'b0;
      end
      rc4_pkg::OP_KS_RD_I: begin
        raddr = i_r;
      end
      rc4_pkg::OP_KS_RD_J: begin
        t_nxt = rval;
        j_nxt = jn_ks;
        raddr = jn_ks;
      end
      rc4_pkg::OP_KS_SWAP_A: begin
        we    = 1'b1;
        waddr = i_r;
        wdata = rval;
      end
      rc4_pkg::OP_KS_SWAP_B: begin
        we    = 1'b1;
        waddr = j_r;
        wdata = t_r;
        i_nxt = BW'(i_r + 1'b1);
        if (kpos_inc >= len_eff) begin
          kpos_nxt = '0;
        end else begin
          kpos_nxt = kpos_inc[rc4_pkg::KPOS_W-1:0];
        end
        // The schedule's own j does not survive into the keystream state.
        if (status.last_step) begin
          j_nxt = '0;
        end
      end
      rc4_pkg::OP_CR_START: begin
        i_nxt    = BW'(i_r + 1'b1);
        raddr    = BW'(i_r + 1'b1);
        data_nxt = in_data_byte;
        exp_nxt  = in_expected_byte;
      end
      rc4_pkg::OP_CR_RD_J: begin
        t_nxt = rval;
        j_nxt = j_cr;
        raddr = j_cr;
      end
      rc4_pkg::OP_CR_SWAP_A: begin
        sj_nxt    = rval;
        we        = 1'b1;
        waddr     = i_r;
        wdata     = rval;
        raddr     = k_addr;
        hit_i_nxt = (k_addr == i_r);
        hit_j_nxt = (k_addr == j_r);
      end
      rc4_pkg::OP_CR_SWAP_B: begin
        we        = 1'b1;
        waddr     = j_r;
        wdata     = t_r;
        res_nxt   = res_cr;
        match_nxt = (res_cr == exp_r);
      end
      default: begin
      end
    endcase
    if (we && (cmd.op != rc4_pkg::OP_SCHED_INIT)) begin
      vld_nxt[waddr] = 1'b1;
    end
  end

  always_comb begin
    out_byte_nxt  = out_byte_r;
    out_match_nxt = out_match_r;
    if (cmd.out_load) begin
      out_byte_nxt  = res_r;
      out_match_nxt = match_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
    rvld_r  <= vld_r[raddr];
    raddr_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      i_r    <= '0;
      j_r    <= '0;
      kpos_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      kpos_r <= kpos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    sj_r        <= sj_nxt;
    hit_i_r     <= hit_i_nxt;
    hit_j_r     <= hit_j_nxt;
    data_r      <= data_nxt;
    exp_r       <= exp_nxt;
    res_r       <= res_nxt;
    match_r     <= match_nxt;
    out_byte_r  <= out_byte_nxt;
    out_match_r <= out_match_nxt;
  end

endmodule

/* rtl/core/rc4_ctrl.sv */
// ----------------------------------------------------------------------------
// RC4 controller
// Sequences the key schedule and keystream steps and owns the input and output handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rc4_stream_cipher_defines.svh"

module rc4_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rc4_pkg::dp_cmd_t           cmd,
  input  rc4_pkg::dp_status_t        status
);

  rc4_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_command == rc4_pkg::CMD_CRYPT) ? rc4_pkg::ST_CR_RD_J
                                                         : rc4_pkg::ST_KS_RD_I;
        end
      end
      rc4_pkg::ST_KS_RD_I:   state_nxt = rc4_pkg::ST_KS_RD_J;
      rc4_pkg::ST_KS_RD_J:   state_nxt = rc4_pkg::ST_KS_SWAP_A;
      rc4_pkg::ST_KS_SWAP_A: state_nxt = rc4_pkg::ST_KS_SWAP_B;
      rc4_pkg::ST_KS_SWAP_B: begin
        state_nxt = status.last_step ? rc4_pkg::ST_PUSH : rc4_pkg::ST_KS_RD_I;
      end
      rc4_pkg::ST_CR_RD_J:   state_nxt = rc4_pkg::ST_CR_SWAP_A;
      rc4_pkg::ST_CR_SWAP_A: state_nxt = rc4_pkg::ST_CR_SWAP_B;
      rc4_pkg::ST_CR_SWAP_B: state_nxt = rc4_pkg::ST_PUSH;
      rc4_pkg::ST_PUSH: begin
        if (out_free) begin
          if (in_valid) begin
            state_nxt = (in_command == rc4_pkg::CMD_CRYPT) ? rc4_pkg::ST_CR_RD_J
                                                           : rc4_pkg::ST_KS_RD_I;
          end else begin
            state_nxt = rc4_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.op       = rc4_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    case (state_r)
      rc4_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = (in_command == rc4_pkg::CMD_CRYPT) ? rc4_pkg::OP_CR_START
                                                      : rc4_pkg::OP_SCHED_INIT;
        end
      end
      rc4_pkg::ST_KS_RD_I:   cmd.op = rc4_pkg::OP_KS_RD_I;
      rc4_pkg::ST_KS_RD_J:   cmd.op = rc4_pkg::OP_KS_RD_J;
      rc4_pkg::ST_KS_SWAP_A: cmd.op = rc4_pkg::OP_KS_SWAP_A;
      rc4_pkg::ST_KS_SWAP_B: cmd.op = rc4_pkg::OP_KS_SWAP_B;
      rc4_pkg::ST_CR_RD_J:   cmd.op = rc4_pkg::OP_CR_RD_J;
      rc4_pkg::ST_CR_SWAP_A: cmd.op = rc4_pkg::OP_CR_SWAP_A;
      rc4_pkg::ST_CR_SWAP_B: cmd.op = rc4_pkg::OP_CR_SWAP_B;
      rc4_pkg::ST_PUSH: begin
        // When the output register is free, the result moves into it and the next item may start at once.
        cmd.out_load = out_free;
        in_ready     = out_free;
        if (out_free && in_valid) begin
          cmd.op = (in_command == rc4_pkg::CMD_CRYPT) ? rc4_pkg::OP_CR_START
                                                      : rc4_pkg::OP_SCHED_INIT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rc4_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `RC4_ASSERT(a_out_after_push, $rose(out_valid_r) |-> $past(state_r == rc4_pkg::ST_PUSH))
  `RC4_ASSERT(a_crypt_start, (in_valid && in_ready && in_command == rc4_pkg::CMD_CRYPT) |=> (state_r == rc4_pkg::ST_CR_RD_J))
  `RC4_ASSERT(a_sched_end, (state_r == rc4_pkg::ST_KS_SWAP_B && status.last_step) |=> (state_r == rc4_pkg::ST_PUSH))
  `RC4_NEVER(a_no_busy_accept, in_ready && !(state_r == rc4_pkg::ST_IDLE || state_r == rc4_pkg::ST_PUSH))

endmodule

/* rtl/core/rc4_stream_cipher.sv */
// ----------------------------------------------------------------------------
// RC4 stream cipher
// RC4 engine with key schedule, keystream XOR and known-plaintext compare.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key words and key length through the cfg_ channel (always
//   ready) while the engine is idle. An input item with in_command set to
//   schedule runs the full key schedule and returns one item of zeros; an
//   item with in_command set to crypt XORs in_data_byte with the next
//   keystream byte and returns out_byte plus out_match against
//   in_expected_byte.
//   Crypt: an accepted byte runs through CR_RD_J, CR_SWAP_A, CR_SWAP_B and
//   PUSH, and no new byte is taken before PUSH with a free output; the
//   single-port permutation store with a registered read sets this (read
//   S[i], read S[j], swap with the keystream read). Schedule: 256 swap
//   steps of KS_RD_I, KS_RD_J, KS_SWAP_A, KS_SWAP_B, then PUSH.
//   Reset leaves the identity permutation with both indices zero, key
//   length 8 and a zero key. A stalled output holds its item in the output
//   register; one more item is accepted and runs up to that register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rc4_stream_cipher (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic [rc4_pkg::BYTE_W-1:0]            in_data_byte,
  input  logic [rc4_pkg::BYTE_W-1:0]            in_expected_byte,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [rc4_pkg::BYTE_W-1:0]            out_byte,
  output logic                                  out_match,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rc4_pkg::KEY_WORD_W-1:0]        cfg_data
);

  rc4_pkg::key_cfg_t   key_cfg_r, key_cfg_nxt;
  rc4_pkg::dp_cmd_t    cmd;
  rc4_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  always_comb begin
    key_cfg_nxt = key_cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        rc4_pkg::CFG_KEY_LOW:  key_cfg_nxt.key_low    = cfg_data;
        rc4_pkg::CFG_KEY_HIGH: key_cfg_nxt.key_high   = cfg_data;
        rc4_pkg::CFG_KEY_LEN:  key_cfg_nxt.key_length = cfg_data[rc4_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_cfg_r.key_low    <= '0;
      key_cfg_r.key_high   <= '0;
      key_cfg_r.key_length <= rc4_pkg::KEY_LEN_RESET;
    end else begin
      key_cfg_r <= key_cfg_nxt;
    end
  end

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .status     (status)
  );

  rc4_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .key_cfg          (key_cfg_r),
    .in_data_byte     (in_data_byte),
    .in_expected_byte (in_expected_byte),
    .out_byte         (out_byte),
    .out_match        (out_match)
  );

endmodule
